### design/subarray_target_sum_counter_unit_assert.svh
// Assertion macros shared by the checker of the target-sum counter.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SUBARRAY_TARGET_SUM_COUNTER_UNIT_ASSERT_SVH
`define SUBARRAY_TARGET_SUM_COUNTER_UNIT_ASSERT_SVH

// Property checked on every rising clock edge outside reset
`define STCS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("stcs check failed");

// Condition that must never be seen
`define STCS_ASSERT_NEVER(lbl, cond) `STCS_ASSERT(lbl, !(cond))

`endif

### design/stcs_pkg.sv
// Package of the target-sum counter: default sizes, controller states, result word.
// No dependencies.
`timescale 1ns / 1ps

package stcs_pkg;

  localparam int MaxItemsDef   = 1024;
  localparam int SampleBitsDef = 16;
  localparam int TargetBits    = 26;
  localparam int MatchW        = 20;
  localparam int OutDataW      = ((MatchW + 7) / 8) * 8;
  localparam int EpochW        = 8;

  typedef enum logic [2:0] {
    STCS_CLEAR,
    STCS_IDLE,
    STCS_INS,
    STCS_LKUP,
    STCS_LCHK,
    STCS_DONE
  } stcs_state_e;

  typedef struct packed {
    logic [MatchW-1:0] match_count;
    logic              overflowed;
    logic              end_of_array;
  } stcs_res_t;

endpackage

### design/stcs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module stcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/stcs_ctrl.sv
// Controller of the target-sum counter: prefix sum, hash insert and lookup with
// linear probing in the prefix table RAM. Depends on stcs_pkg and stcs_ram.
`timescale 1ns / 1ps

module stcs_ctrl #(
  parameter int MaxItems   = stcs_pkg::MaxItemsDef,
  parameter int SampleBits = stcs_pkg::SampleBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SampleBits-1:0]         sample_i,
  input  logic                                 is_last_i,
  input  logic signed [stcs_pkg::TargetBits-1:0] target_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output stcs_pkg::stcs_res_t                  res_o
);
  import stcs_pkg::*;

  localparam int PfxW  = SampleBits + $clog2(MaxItems) + 1;
  localparam int KeyW  = ((PfxW > TargetBits) ? PfxW : TargetBits) + 1;
  localparam int CntW  = $clog2(MaxItems + 1);
  localparam int ItemW = $clog2(MaxItems + 1);
  localparam int IdxW  = $clog2(MaxItems) + 1;
  localparam int Depth = 1 << IdxW;
  localparam int WordW = EpochW + KeyW + CntW;

  stcs_state_e state_q, state_d;
  logic [IdxW-1:0]           addr_q, addr_d;
  logic [KeyW-1:0]           key_q, key_d;
  logic signed [PfxW-1:0]    prefix_q, prefix_d;
  logic signed [SampleBits-1:0] sample_q, sample_d;
  logic                      last_q, last_d;
  logic [MatchW-1:0]         matches_q, matches_d;
  logic [ItemW-1:0]          items_q, items_d;
  logic                      ovf_q, ovf_d;
  logic [EpochW-1:0]         epoch_q, epoch_d;

  logic             re, we;
  logic [IdxW-1:0]  raddr, waddr;
  logic [WordW-1:0] rdata, wdata;
  logic [EpochW-1:0] ent_epoch;
  logic [KeyW-1:0]   ent_key;
  logic [CntW-1:0]   ent_cnt;
  logic              ent_live, ent_hit;
  logic [KeyW-1:0]   pfx_key, look_key;
  logic [MatchW:0]   sum;

  // fold the key bits into a table index
  function automatic logic [IdxW-1:0] hash_f(input logic [KeyW-1:0] k);
    logic [IdxW-1:0] h;
    h = '0;
    for (int i = 0; i < KeyW; i++) begin
      h[i % IdxW] = h[i % IdxW] ^ k[i];
    end
    return h;
  endfunction

  stcs_ram #(
    .Width(WordW),
    .Depth(Depth)
  ) u_tbl (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // unpack the table word read last cycle
  assign {ent_epoch, ent_key, ent_cnt} = rdata;
  assign ent_live = (ent_epoch == epoch_q);
  assign ent_hit  = ent_live && (ent_key == key_q);
  assign pfx_key  = KeyW'(prefix_q);
  assign look_key = KeyW'(prefix_q) - KeyW'(target_i);
  assign sum      = {1'b0, matches_q} + (MatchW + 1)'(ent_cnt);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      STCS_CLEAR: if (&addr_q) state_d = STCS_IDLE;
      STCS_IDLE: begin
        if (in_valid_i) begin
          state_d = (items_q >= ItemW'(MaxItems)) ? STCS_DONE : STCS_INS;
        end
      end
      STCS_INS:  if (!ent_live || ent_hit) state_d = STCS_LKUP;
      STCS_LKUP: state_d = STCS_LCHK;
      STCS_LCHK: if (!ent_live || ent_hit) state_d = STCS_DONE;
      STCS_DONE: begin
        if (res_ready_i) begin
          state_d = (last_q && (&epoch_q)) ? STCS_CLEAR : STCS_IDLE;
        end
      end
      default: state_d = STCS_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    addr_d    = addr_q;
    key_d     = key_q;
    prefix_d  = prefix_q;
    sample_d  = sample_q;
    last_d    = last_q;
    matches_d = matches_q;
    items_d   = items_q;
    ovf_d     = ovf_q;
    epoch_d   = epoch_q;
    re        = 1'b0;
    raddr     = addr_q;
    we        = 1'b0;
    waddr     = addr_q;
    wdata     = {epoch_q, key_q, CntW'(1)};
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      STCS_CLEAR: begin
        // sweep the table back to epoch zero
        we     = 1'b1;
        wdata  = '0;
        addr_d = addr_q + IdxW'(1);
      end
      STCS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          sample_d = sample_i;
          last_d   = is_last_i;
          if (items_q >= ItemW'(MaxItems)) begin
            ovf_d = 1'b1;
          end else begin
            key_d  = pfx_key;
            addr_d = hash_f(pfx_key);
            re     = 1'b1;
            raddr  = hash_f(pfx_key);
          end
        end
      end
      STCS_INS: begin
        // record the old prefix, then advance it
        if (ent_hit) begin
          we    = 1'b1;
          wdata = {epoch_q, key_q, ent_cnt + CntW'(1)};
        end else if (!ent_live) begin
          we = 1'b1;
        end
        if (!ent_live || ent_hit) begin
          prefix_d = prefix_q + PfxW'(sample_q);
          items_d  = items_q + ItemW'(1);
        end else begin
          addr_d = addr_q + IdxW'(1);
          re     = 1'b1;
          raddr  = addr_q + IdxW'(1);
        end
      end
      STCS_LKUP: begin
        key_d  = look_key;
        addr_d = hash_f(look_key);
        re     = 1'b1;
        raddr  = hash_f(look_key);
      end
      STCS_LCHK: begin
        if (ent_hit) begin
          matches_d = sum[MatchW] ? {MatchW{1'b1}} : sum[MatchW-1:0];
        end else if (ent_live) begin
          addr_d = addr_q + IdxW'(1);
          re     = 1'b1;
          raddr  = addr_q + IdxW'(1);
        end
      end
      STCS_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i && last_q) begin
          prefix_d  = '0;
          matches_d = '0;
          items_d   = '0;
          ovf_d     = 1'b0;
          if (&epoch_q) begin
            epoch_d = EpochW'(1);
            addr_d  = '0;
          end else begin
            epoch_d = epoch_q + EpochW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o.match_count  = matches_q;
  assign res_o.overflowed   = ovf_q;
  assign res_o.end_of_array = last_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= STCS_CLEAR;
      addr_q    <= '0;
      prefix_q  <= '0;
      matches_q <= '0;
      items_q   <= '0;
      ovf_q     <= 1'b0;
      epoch_q   <= EpochW'(1);
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      prefix_q  <= prefix_d;
      matches_q <= matches_d;
      items_q   <= items_d;
      ovf_q     <= ovf_d;
      epoch_q   <= epoch_d;
      last_q    <= last_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    sample_q <= sample_d;
  end

endmodule

### design/subarray_target_sum_counter_unit.sv
// Top level of the target-sum counter: stream ports, target register, output word.
// Depends on stcs_pkg, stcs_ctrl and stcs_ram.
`timescale 1ns / 1ps

// Counts, per array of signed samples closed by tlast, the contiguous runs whose
// sum equals target_sum, and returns one word per sample with the count so far.
// Each prefix sum is kept in a hash table RAM of 2^(clog2(MaxItems)+1) entries with
// linear probing; each sample takes an insert and then a lookup, each reading the
// registered RAM port once per probe, and the insert writes back the entry that it
// finds or claims. A new sample is accepted only once the last one's result is passed on.
// After reset, and after every 255th array, a clearing pass over all the entries
// runs before the next sample is taken. Samples beyond MaxItems in one array only
// raise overflowed and repeat the held count.
module subarray_target_sum_counter_unit #(
  parameter int MaxItems   = stcs_pkg::MaxItemsDef,
  parameter int SampleBits = stcs_pkg::SampleBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SampleBits + 7) / 8) * 8-1:0] s_axis_tdata,  // sample
  input  logic                                  s_axis_tlast,  // is_last
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [stcs_pkg::OutDataW-1:0]         m_axis_tdata,  // match_count
  output logic                                  m_axis_tuser,  // overflowed
  output logic                                  m_axis_tlast,  // end_of_array
  input  logic                                  cfg_we_i,
  input  logic [stcs_pkg::TargetBits-1:0]       cfg_wdata_i    // target_sum
);
  import stcs_pkg::*;

  logic signed [TargetBits-1:0] target_q;
  logic      res_valid, res_ready;
  stcs_res_t res;
  logic      out_valid_q;
  stcs_res_t out_q;

  // target register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  stcs_ctrl #(
    .MaxItems  (MaxItems),
    .SampleBits(SampleBits)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sample_i   (s_axis_tdata[SampleBits-1:0]),
    .is_last_i  (s_axis_tlast),
    .target_i   (target_q),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output word register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_q.match_count);
  assign m_axis_tuser  = out_q.overflowed;
  assign m_axis_tlast  = out_q.end_of_array;

endmodule

### design/stcs_chk.sv
// Port-level checker of the target-sum counter, bound to the top level.
// Depends on subarray_target_sum_counter_unit_assert.svh and stcs_pkg.
`timescale 1ns / 1ps
`include "subarray_target_sum_counter_unit_assert.svh"

module stcs_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [stcs_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);
  import stcs_pkg::*;

  logic              out_acc;
  logic              fresh_q;
  logic              ovf_seen_q;
  logic [MatchW-1:0] prev_q;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  // track array boundaries as seen on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q    <= 1'b1;
      ovf_seen_q <= 1'b0;
      prev_q     <= '0;
    end else if (out_acc) begin
      fresh_q    <= m_axis_tlast;
      ovf_seen_q <= m_axis_tuser && !m_axis_tlast;
      prev_q     <= m_axis_tlast ? '0 : m_axis_tdata[MatchW-1:0];
    end
  end

  `STCS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `STCS_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `STCS_ASSERT_NEVER(a_first_no_ovf, out_acc && fresh_q && m_axis_tuser)
  `STCS_ASSERT_NEVER(a_ovf_sticky, out_acc && ovf_seen_q && !m_axis_tuser)
  `STCS_ASSERT_NEVER(a_count_mono, out_acc && (m_axis_tdata[MatchW-1:0] < prev_q))

endmodule

bind subarray_target_sum_counter_unit stcs_chk u_stcs_chk (.*);
